/* rtl/pcic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic_pkg: shared types and constants of the polygon cell inversion check
// Widths, the fault codes, the corner job record passed from front to back,
// and the coordinate difference helper.
// ----------------------------------------------------------------------------
package pcic_pkg;

  // field widths
  localparam int COORD_W        = 32;
  localparam int ID_W           = 32;
  localparam int NODE_W         = 31;
  localparam int COUNT_W        = 32;
  localparam int DELTA_W        = COORD_W + 1;
  localparam int PROD_W         = 2 * DELTA_W;

  // defaults for top level parameters
  localparam int COORD_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // corner slots per vertex job: the running corner and the two wrap corners
  localparam int NUM_CORNERS      = 3;
  localparam int CORNER_RUN       = 0;
  localparam int CORNER_WRAP_LAST = 1;
  localparam int CORNER_WRAP_HEAD = 2;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_SHORT      = 2'd1,
    FAULT_BAD_ID     = 2'd2,
    FAULT_BAD_CORNER = 2'd3
  } fault_kind_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  // one classified vertex, waiting for the cross products
  typedef struct packed {
    logic                         new_mesh;
    logic                         last;
    logic                         short_cell;
    logic                         id_fault;
    logic [NUM_CORNERS-1:0]       corner_en;
    logic [NUM_CORNERS-1:0][DELTA_W-1:0] dx1;
    logic [NUM_CORNERS-1:0][DELTA_W-1:0] dy1;
    logic [NUM_CORNERS-1:0][DELTA_W-1:0] dx2;
    logic [NUM_CORNERS-1:0][DELTA_W-1:0] dy2;
  } corner_job_t;

  // exact difference of two coordinates
  function automatic delta_t coord_diff(coord_t a, coord_t b);
    delta_t ea;
    delta_t eb;
    ea = DELTA_W'(a);
    eb = DELTA_W'(b);
    return ea - eb;
  endfunction

endpackage

/* rtl/pcic_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic channel interfaces
// Vertex request channel and cell result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcic_vtx_if;
  logic                             valid;
  logic                             ready;
  logic signed [pcic_pkg::ID_W-1:0]    vertex_id;
  logic signed [pcic_pkg::COORD_W-1:0] vertex_x;
  logic signed [pcic_pkg::COORD_W-1:0] vertex_y;
  logic                             last_vertex;
  logic                             new_mesh;

  modport source (output valid, vertex_id, vertex_x, vertex_y, last_vertex, new_mesh,
                  input ready);
  modport sink   (input valid, vertex_id, vertex_x, vertex_y, last_vertex, new_mesh,
                  output ready);
endinterface

interface pcic_res_if;
  logic                         valid;
  logic                         ready;
  logic                         cell_inverted;
  logic [1:0]                   fault_kind;
  logic [pcic_pkg::COUNT_W-1:0] inverted_total;
  logic [pcic_pkg::COUNT_W-1:0] cell_total;

  modport source (output valid, cell_inverted, fault_kind, inverted_total, cell_total,
                  input ready);
  modport sink   (input valid, cell_inverted, fault_kind, inverted_total, cell_total,
                  output ready);
endinterface

/* rtl/pcic_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic_front: vertex intake and classification
// Holds the node count, tracks the ring (first, second, previous, current),
// checks ids and forms the edge deltas of every corner closed by a vertex.
// ----------------------------------------------------------------------------
module pcic_front #(
  parameter int COORD_BITS = pcic_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pcic_pkg::NODE_W-1:0] cfg_wr_data,
  pcic_vtx_if.sink                    in_vtx,
  input  logic                        q_full,
  output logic                        q_push,
  output pcic_pkg::corner_job_t       q_job
);

  localparam int SHIFT = pcic_pkg::COORD_W - COORD_BITS;

  logic [pcic_pkg::NODE_W-1:0] node_count_r;
  pcic_pkg::coord_t first_x_r, first_y_r, second_x_r, second_y_r;
  pcic_pkg::coord_t prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic [1:0]       vseen_r;
  logic             id_fault_r;

  pcic_pkg::coord_t vx_sh, vy_sh, vx, vy;
  logic             id_bad, id_fault_now, accept, ring_open;

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  assign in_vtx.ready = !q_full;
  assign accept       = in_vtx.valid && !q_full;
  assign q_push       = accept;

  // keep the low coordinate bits, sign extended
  always_comb begin
    vx_sh = in_vtx.vertex_x <<< SHIFT;
    vy_sh = in_vtx.vertex_y <<< SHIFT;
    vx    = vx_sh >>> SHIFT;
    vy    = vy_sh >>> SHIFT;
  end

  // id range check, negative ids are always out of range
  assign id_bad = in_vtx.vertex_id[pcic_pkg::ID_W-1] ||
                  (in_vtx.vertex_id[pcic_pkg::NODE_W-1:0] >= node_count_r);
  assign id_fault_now = id_fault_r || id_bad;
  assign ring_open    = vseen_r[1];

  // corner job: running corner plus both wrap corners on the closing vertex
  always_comb begin
    q_job            = '0;
    q_job.new_mesh   = in_vtx.new_mesh;
    q_job.last       = in_vtx.last_vertex;
    q_job.short_cell = in_vtx.last_vertex && !ring_open;
    q_job.id_fault   = id_fault_now;
    q_job.corner_en[pcic_pkg::CORNER_RUN]       = ring_open;
    q_job.corner_en[pcic_pkg::CORNER_WRAP_LAST] = ring_open && in_vtx.last_vertex;
    q_job.corner_en[pcic_pkg::CORNER_WRAP_HEAD] = ring_open && in_vtx.last_vertex;
    // previous, current, new
    q_job.dx1[pcic_pkg::CORNER_RUN] = pcic_pkg::coord_diff(cur_x_r, prev_x_r);
    q_job.dy1[pcic_pkg::CORNER_RUN] = pcic_pkg::coord_diff(cur_y_r, prev_y_r);
    q_job.dx2[pcic_pkg::CORNER_RUN] = pcic_pkg::coord_diff(vx, cur_x_r);
    q_job.dy2[pcic_pkg::CORNER_RUN] = pcic_pkg::coord_diff(vy, cur_y_r);
    // current, new, first
    q_job.dx1[pcic_pkg::CORNER_WRAP_LAST] = pcic_pkg::coord_diff(vx, cur_x_r);
    q_job.dy1[pcic_pkg::CORNER_WRAP_LAST] = pcic_pkg::coord_diff(vy, cur_y_r);
    q_job.dx2[pcic_pkg::CORNER_WRAP_LAST] = pcic_pkg::coord_diff(first_x_r, vx);
    q_job.dy2[pcic_pkg::CORNER_WRAP_LAST] = pcic_pkg::coord_diff(first_y_r, vy);
    // new, first, second
    q_job.dx1[pcic_pkg::CORNER_WRAP_HEAD] = pcic_pkg::coord_diff(first_x_r, vx);
    q_job.dy1[pcic_pkg::CORNER_WRAP_HEAD] = pcic_pkg::coord_diff(first_y_r, vy);
    q_job.dx2[pcic_pkg::CORNER_WRAP_HEAD] = pcic_pkg::coord_diff(second_x_r, first_x_r);
    q_job.dy2[pcic_pkg::CORNER_WRAP_HEAD] = pcic_pkg::coord_diff(second_y_r, first_y_r);
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vseen_r    <= 2'd0;
      id_fault_r <= 1'b0;
    end else if (accept) begin
      if (in_vtx.last_vertex) begin
        vseen_r    <= 2'd0;
        id_fault_r <= 1'b0;
      end else begin
        vseen_r    <= (vseen_r == 2'd3) ? vseen_r : vseen_r + 2'd1;
        id_fault_r <= id_fault_now;
      end
    end
  end

  // ring vertex registers
  always_ff @(posedge clk) begin
    if (accept) begin
      case (vseen_r)
        2'd0: begin
          first_x_r <= vx;
          first_y_r <= vy;
        end
        2'd1: begin
          second_x_r <= vx;
          second_y_r <= vy;
          prev_x_r   <= cur_x_r;
          prev_y_r   <= cur_y_r;
        end
        default: begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
        end
      endcase
      cur_x_r <= vx;
      cur_y_r <= vy;
    end
  end

endmodule

/* rtl/pcic_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic_queue: short job queue between front and back
// Register based first-in first-out buffer of corner jobs.
// ----------------------------------------------------------------------------
module pcic_queue #(
  parameter int DEPTH = pcic_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pcic_pkg::corner_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output pcic_pkg::corner_job_t head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcic_pkg::corner_job_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/pcic_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic_back: cross product and verdict pipeline
// Stage one forms both edge products of every corner; stage two
// compares them, keeps the sticky corner fault and the running totals, and
// loads the result register on the closing vertex.
// ----------------------------------------------------------------------------
module pcic_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  pcic_pkg::corner_job_t q_job,
  output logic                  q_pop,
  pcic_res_if.source            out_res
);

  localparam int NC = pcic_pkg::NUM_CORNERS;

  logic                                s1_valid_r;
  logic                                s1_new_mesh_r, s1_last_r, s1_short_r, s1_id_fault_r;
  logic [NC-1:0]                       s1_en_r;
  logic signed [pcic_pkg::PROD_W-1:0]  lp_r [NC];
  logic signed [pcic_pkg::PROD_W-1:0]  rp_r [NC];
  logic signed [pcic_pkg::PROD_W-1:0]  lp [NC];
  logic signed [pcic_pkg::PROD_W-1:0]  rp [NC];

  logic                         out_valid_r, corner_fault_r;
  logic                         cell_inverted_r;
  pcic_pkg::fault_kind_t        fault_kind_r;
  logic [pcic_pkg::COUNT_W-1:0] inverted_count_r, cell_count_r;

  logic                         advance, s1_load;
  logic [NC-1:0]                bad;
  logic                         corner_fault_now;
  pcic_pkg::fault_kind_t        kind;
  logic [pcic_pkg::COUNT_W-1:0] inv_base, cell_base;

  // whole back pipe moves unless a result is held
  assign advance = !out_valid_r || out_res.ready;
  assign s1_load = (!s1_valid_r || advance) && !q_empty;
  assign q_pop   = s1_load;

  // edge products per corner
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      lp[i] = $signed(q_job.dx1[i]) * $signed(q_job.dy2[i]);
      rp[i] = $signed(q_job.dy1[i]) * $signed(q_job.dx2[i]);
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= !q_empty;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_new_mesh_r <= q_job.new_mesh;
      s1_last_r     <= q_job.last;
      s1_short_r    <= q_job.short_cell;
      s1_id_fault_r <= q_job.id_fault;
      s1_en_r       <= q_job.corner_en;
      for (int i = 0; i < NC; i++) begin
        lp_r[i] <= lp[i];
        rp_r[i] <= rp[i];
      end
    end
  end

  // corner verdict: a cross product of zero or less is bad
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      bad[i] = s1_en_r[i] && (lp_r[i] <= rp_r[i]);
    end
    corner_fault_now = corner_fault_r || (|bad);
    if (s1_short_r) begin
      kind = pcic_pkg::FAULT_SHORT;
    end else if (s1_id_fault_r) begin
      kind = pcic_pkg::FAULT_BAD_ID;
    end else if (corner_fault_now) begin
      kind = pcic_pkg::FAULT_BAD_CORNER;
    end else begin
      kind = pcic_pkg::FAULT_NONE;
    end
    inv_base  = s1_new_mesh_r ? '0 : inverted_count_r;
    cell_base = s1_new_mesh_r ? '0 : cell_count_r;
  end

  // sticky corner fault and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_fault_r   <= 1'b0;
      inverted_count_r <= '0;
      cell_count_r     <= '0;
    end else if (s1_valid_r && advance) begin
      if (s1_last_r) begin
        corner_fault_r   <= 1'b0;
        cell_count_r     <= (&cell_base) ? cell_base : cell_base + 1'b1;
        inverted_count_r <= ((kind == pcic_pkg::FAULT_NONE) || (&inv_base)) ?
                            inv_base : inv_base + 1'b1;
      end else begin
        corner_fault_r   <= corner_fault_now;
        cell_count_r     <= cell_base;
        inverted_count_r <= inv_base;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_last_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && s1_last_r) begin
      fault_kind_r    <= kind;
      cell_inverted_r <= (kind != pcic_pkg::FAULT_NONE);
    end
  end

  // totals only change on advance, so the counters stand with the result
  assign out_res.valid          = out_valid_r;
  assign out_res.cell_inverted  = cell_inverted_r;
  assign out_res.fault_kind     = fault_kind_r;
  assign out_res.inverted_total = inverted_count_r;
  assign out_res.cell_total     = cell_count_r;

endmodule

/* rtl/polygon_cell_inversion_check_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_cell_inversion_check_top: mesh cell convexity and orientation check
// Accepts one vertex per cycle while the queue is not full; the front classifies, the back forms the
// cross products; a short queue separates the two.
// ----------------------------------------------------------------------------
// throughput: one vertex request per cycle, sustained while results are taken
// path: after its closing vertex is accepted, a cell result passes the queue, stage one and the result register
// the two wrap corners are computed beside the running corner, so the closing
// vertex is taken like any other; only a held result stalls the back pipe
// reset: synchronous active low, clears node count, ring state, queue, totals
module polygon_cell_inversion_check_top #(
  parameter int COORD_BITS  = pcic_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = pcic_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [pcic_pkg::NODE_W-1:0] cfg_wr_data,
  pcic_vtx_if.sink                    in_vtx,
  pcic_res_if.source                  out_res
);

  logic                  q_push, q_full, q_pop, q_empty;
  pcic_pkg::corner_job_t push_job, head_job;

  // intake and classification
  pcic_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_vtx      (in_vtx),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // decoupling queue
  pcic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // cross products and verdict
  pcic_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

/* rtl/pcic_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcic_checker: port level checks of the inversion check block
// Watches the result channel for held results and consistent verdicts.
// ----------------------------------------------------------------------------
module pcic_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         cell_inverted,
  input logic [1:0]                   fault_kind,
  input logic [pcic_pkg::COUNT_W-1:0] inverted_total,
  input logic [pcic_pkg::COUNT_W-1:0] cell_total
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fault_kind) &&
      $stable(cell_total) && $stable(inverted_total))
    else $error("stalled result changed");

  // verdict agrees with fault kind
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cell_inverted == (fault_kind != pcic_pkg::FAULT_NONE)))
    else $error("verdict and fault kind disagree");

  // inverted cells never outnumber cells
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inverted_total <= cell_total) && (cell_total != '0))
    else $error("running totals inconsistent");

  // an inverted cell is counted in the inverted total
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cell_inverted |-> (inverted_total != '0))
    else $error("inverted cell not counted");

endmodule

bind polygon_cell_inversion_check_top pcic_checker u_pcic_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .cell_inverted  (out_res.cell_inverted),
  .fault_kind     (out_res.fault_kind),
  .inverted_total (out_res.inverted_total),
  .cell_total     (out_res.cell_total)
);
